### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the odometry block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define DDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define DDO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### rtl/core/ddo_pkg.sv
// ---------------------------------------------------------------------------
// Odometry integrator package
// Types, widths, constants and the arctangent table of the odometry block.
// ---------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 24;
   localparam int ATAN_IDX_W       = 5;
   localparam int CORDIC_W         = 34;

   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = 64;
   localparam int DIV_N_W = 44;
   localparam int DIV_D_W = 31;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 34'sh026DD3B6A;
   localparam logic [DIV_D_W-1:0]         WRAP_2PI_Q28 = 31'd1686629713;
   localparam logic [DIV_D_W-1:0]         CM_TO_M_DIV  = 31'd26214400;
   localparam logic [MUL_B_W-1:0]         INV_4PI_Q24  = 24'd1335088;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_DATA_W-1:0] INV_WHEELBASE_RST = 16'd6425;
   localparam logic [CSR_DATA_W-1:0] TICK_SECONDS_RST  = 16'd1311;
   localparam logic [CSR_DATA_W-1:0] WHEEL_GAIN_RST    = 16'd41218;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_WHEELBASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_SECONDS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_GAIN    = 2'd2;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] left_vel;
      logic signed [15:0] right_vel;
      logic [15:0]        duration_ticks;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
      logic signed [15:0] linear_speed;
      logic signed [23:0] turn_rate;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] left_wheel_angle;
      logic signed [31:0] right_wheel_angle;
      logic signed [15:0] left_wheel_speed;
      logic signed [15:0] right_wheel_speed;
      logic               command_done;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef enum logic [4:0] {
      STEP_OMEGA = 5'd0,
      STEP_CORD1 = 5'd1,
      STEP_VC    = 5'd2,
      STEP_VCDT  = 5'd3,
      STEP_DIVX  = 5'd4,
      STEP_VS    = 5'd5,
      STEP_VSDT  = 5'd6,
      STEP_DIVY  = 5'd7,
      STEP_OMDT  = 5'd8,
      STEP_OMK   = 5'd9,
      STEP_LG    = 5'd10,
      STEP_LGDT  = 5'd11,
      STEP_LDIV  = 5'd12,
      STEP_RG    = 5'd13,
      STEP_RGDT  = 5'd14,
      STEP_RDIV  = 5'd15,
      STEP_CORD2 = 5'd16
   } step_type;

   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2FA;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ddo_serial_mul.sv
// ---------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add signed multiplier taking one bit of the second operand per
// cycle, most significant bit first.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_serial_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ddo_pkg::MUL_A_W-1:0]   a,
   input  logic signed [ddo_pkg::MUL_B_W-1:0]   b,
   output logic                                 done,
   output logic signed [ddo_pkg::MUL_P_W-1:0]   product
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          bit_ff, bit_in;
   logic signed [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0]        b_ff, b_in;
   logic signed [MUL_P_W-1:0] acc_ff, acc_in;
   logic signed [MUL_P_W-1:0] addend;

   always_comb begin
      addend = '0;
      if (b_ff[MUL_B_W-1]) begin
         if (bit_ff == CNT_W'(MUL_B_W-1)) begin
            addend = -MUL_P_W'(a_ff);
         end else begin
            addend = MUL_P_W'(a_ff);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = CNT_W'(MUL_B_W-1);
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + addend;
         b_in   = {b_ff[MUL_B_W-2:0], 1'b0};
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

### rtl/core/ddo_serial_div.sv
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ddo_pkg::DIV_N_W-1:0]   dividend,
   input  logic [ddo_pkg::DIV_D_W-1:0]   divisor,
   output logic                          done,
   output logic [ddo_pkg::DIV_N_W-1:0]   quotient,
   output logic [ddo_pkg::DIV_D_W-1:0]   remainder
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] n_ff, n_in;
   logic [DIV_D_W-1:0] d_ff, d_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   assign trial = {rem_ff, n_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_N_W-1);
         n_in    = dividend;
         d_in    = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_D_W'(trial - {1'b0, d_ff}) : DIV_D_W'(trial);
         n_in   = {n_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = n_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/core/ddo_cordic.sv
// ---------------------------------------------------------------------------
// Iterative CORDIC
// Sine and cosine in signed Q3.30 of an angle where 2^32 is a full turn, one
// rotation step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_cordic #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [31:0]                           angle,
   output logic                                  done,
   output logic signed [ddo_pkg::CORDIC_W-1:0]   cos_out,
   output logic signed [ddo_pkg::CORDIC_W-1:0]   sin_out
);
   import ddo_pkg::*;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       neg_ff, neg_in;
   logic [ATAN_IDX_W-1:0]      i_ff, i_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [31:0]                quarter, folded;
   logic signed [CORDIC_W-1:0] atan_v, dx, dy;

   assign quarter = angle + 32'h4000_0000;
   assign folded  = quarter[31] ? angle + 32'h8000_0000 : angle;
   assign atan_v  = signed'({2'b00, atan_entry(i_ff)});
   assign dx      = y_ff >>> i_ff;
   assign dy      = x_ff >>> i_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      i_in    = i_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = quarter[31];
         i_in    = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = CORDIC_W'(signed'(folded));
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ATAN_IDX_W'(CORDIC_STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      i_ff   <= i_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

### rtl/core/diff_drive_odometry_integrator.sv
// ---------------------------------------------------------------------------
// Differential-drive odometry integrator
// Dead-reckoning of pose, heading quaternion and wheel angles from held
// wheel speeds, one integration step per tick beat under an active command.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   req_     in         req_valid / req_stall   ddo_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall   ddo_pkg::rsp_type
//   csr_     in         csr_write_enable        csr_index, csr_write_data
//
// A command beat gives no result.
// A tick beat runs eleven serial multiplies, four serial divisions and two
// CORDIC passes, one after another.
// Reset is synchronous and leaves the block idle with the reset pose.
// A result waits in the output register under rsp_stall while a new beat
// may still be accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry_integrator #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ddo_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ddo_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ddo_pkg::*;

   state_type                  state_ff, state_in;
   step_type                   step_ff, step_in;
   logic [CSR_DATA_W-1:0]      ibw_ff, ibw_in, dt_ff, dt_in, gain_ff, gain_in;
   logic signed [31:0]         x_ff, x_in, y_ff, y_in;
   logic [31:0]                heading_ff, heading_in;
   logic signed [31:0]         left_ang_ff, left_ang_in, right_ang_ff, right_ang_in;
   logic signed [15:0]         held_l_ff, held_l_in, held_r_ff, held_r_in;
   logic [15:0]                held_dur_ff, held_dur_in, ticks_ff, ticks_in;
   logic                       active_ff, active_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;
   logic signed [15:0]         v_ff, v_in;
   logic signed [23:0]         omega_ff, omega_in;
   logic signed [CORDIC_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [15:0]         qz_ff, qz_in, qw_ff, qw_in;
   logic signed [MUL_A_W-1:0]  tmp_ff, tmp_in;
   logic                       neg_ff, neg_in;
   logic [DIV_N_W-1:0]         dvd_ff, dvd_in;

   logic                       mul_start, div_start, cor_start;
   logic                       mul_done, div_done, cor_done, unit_done;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_p;
   logic [DIV_D_W-1:0]         div_d;
   logic [DIV_N_W-1:0]         div_q;
   logic [DIV_D_W-1:0]         div_r;
   logic [31:0]                cor_angle;
   logic signed [CORDIC_W-1:0] cor_c, cor_s;
   logic                       req_accept;
   logic                       is_cordic, is_div;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < 48'shFFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [CORDIC_W-1:0] v);
      logic signed [15:0] r;
      if (v > 34'sh0_0000_7FFF) begin
         r = 16'sh7FFF;
      end else if (v < 34'sh3_FFFF_8000) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign is_cordic  = (step_ff == STEP_CORD1) || (step_ff == STEP_CORD2);
   assign is_div     = (step_ff == STEP_DIVX) || (step_ff == STEP_DIVY) ||
                       (step_ff == STEP_LDIV) || (step_ff == STEP_RDIV);
   assign cor_start  = (state_ff == ST_ISSUE) && is_cordic;
   assign div_start  = (state_ff == ST_ISSUE) && is_div;
   assign mul_start  = (state_ff == ST_ISSUE) && !is_cordic && !is_div;
   assign unit_done  = is_cordic ? cor_done : (is_div ? div_done : mul_done);
   assign cor_angle  = (step_ff == STEP_CORD1) ? {heading_ff[30:0], 1'b0} : heading_ff;
   assign div_d      = ((step_ff == STEP_DIVX) || (step_ff == STEP_DIVY)) ?
                       CM_TO_M_DIV : WRAP_2PI_Q28;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      logic signed [16:0] diff;
      diff  = 17'(held_r_ff) - 17'(held_l_ff);
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         STEP_OMEGA: begin
            mul_a = MUL_A_W'(diff);
            mul_b = {8'd0, ibw_ff};
         end
         STEP_VC: begin
            mul_a = MUL_A_W'(cos_ff);
            mul_b = MUL_B_W'(v_ff);
         end
         STEP_VS: begin
            mul_a = MUL_A_W'(sin_ff);
            mul_b = MUL_B_W'(v_ff);
         end
         STEP_VCDT, STEP_VSDT, STEP_OMK, STEP_LGDT, STEP_RGDT: begin
            mul_a = tmp_ff;
            mul_b = (step_ff == STEP_OMK) ? INV_4PI_Q24 : {8'd0, dt_ff};
         end
         STEP_OMDT: begin
            mul_a = MUL_A_W'(omega_ff);
            mul_b = {8'd0, dt_ff};
         end
         STEP_LG: begin
            mul_a = MUL_A_W'(held_l_ff);
            mul_b = {8'd0, gain_ff};
         end
         STEP_RG: begin
            mul_a = MUL_A_W'(held_r_ff);
            mul_b = {8'd0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      logic signed [MUL_P_W-1:0] sh;
      logic signed [MUL_P_W-1:0] mag;
      logic signed [47:0]        q;
      logic signed [47:0]        wide;
      logic signed [31:0]        r;
      logic [15:0]               ticks_next;
      logic                      finished;

      sh         = '0;
      mag        = '0;
      q          = '0;
      wide       = '0;
      r          = '0;
      ticks_next = '0;
      finished   = 1'b0;

      state_in     = state_ff;
      step_in      = step_ff;
      ibw_in       = ibw_ff;
      dt_in        = dt_ff;
      gain_in      = gain_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      heading_in   = heading_ff;
      left_ang_in  = left_ang_ff;
      right_ang_in = right_ang_ff;
      held_l_in    = held_l_ff;
      held_r_in    = held_r_ff;
      held_dur_in  = held_dur_ff;
      ticks_in     = ticks_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      v_in         = v_ff;
      omega_in     = omega_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      qz_in        = qz_ff;
      qw_in        = qw_ff;
      tmp_in       = tmp_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INV_WHEELBASE: ibw_in  = csr_write_data;
            CSR_TICK_SECONDS:  dt_in   = csr_write_data;
            CSR_WHEEL_GAIN:    gain_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.kind == KIND_COMMAND) begin
                  held_l_in   = req_data.left_vel;
                  held_r_in   = req_data.right_vel;
                  held_dur_in = req_data.duration_ticks;
                  ticks_in    = '0;
                  active_in   = 1'b1;
               end else if (active_ff) begin
                  v_in     = 16'((17'(held_l_ff) + 17'(held_r_ff)) >>> 1);
                  step_in  = STEP_OMEGA;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               case (step_ff)
                  STEP_OMEGA: begin
                     sh = mul_p >>> 8;
                     if (sh > 64'sh7F_FFFF) begin
                        omega_in = 24'sh7F_FFFF;
                     end else if (sh < -64'sh80_0000) begin
                        omega_in = 24'sh80_0000;
                     end else begin
                        omega_in = sh[23:0];
                     end
                  end
                  STEP_CORD1: begin
                     cos_in = cor_c;
                     sin_in = cor_s;
                  end
                  STEP_VC, STEP_VS: begin
                     tmp_in = MUL_A_W'(mul_p >>> 20);
                  end
                  STEP_VCDT, STEP_VSDT: begin
                     neg_in = mul_p[MUL_P_W-1];
                     mag    = mul_p[MUL_P_W-1] ? -mul_p : mul_p;
                     dvd_in = mag[DIV_N_W-1:0];
                  end
                  STEP_DIVX, STEP_DIVY: begin
                     q = signed'(48'(div_q));
                     if (neg_ff) begin
                        q = -q - 48'(div_r != '0);
                     end
                     if (step_ff == STEP_DIVX) begin
                        x_in = sat32(48'(x_ff) + q);
                     end else begin
                        y_in = sat32(48'(y_ff) + q);
                     end
                  end
                  STEP_OMDT, STEP_LG, STEP_RG: begin
                     tmp_in = MUL_A_W'(mul_p);
                  end
                  STEP_OMK: begin
                     heading_in = heading_ff + mul_p[55:24];
                  end
                  STEP_LGDT, STEP_RGDT: begin
                     sh   = mul_p >>> 12;
                     wide = ((step_ff == STEP_LGDT) ? 48'(left_ang_ff) : 48'(right_ang_ff))
                            + 48'(sh);
                     neg_in = wide[47];
                     mag    = wide[47] ? 64'(-wide) : 64'(wide);
                     dvd_in = mag[DIV_N_W-1:0];
                  end
                  STEP_LDIV, STEP_RDIV: begin
                     r = signed'({1'b0, div_r});
                     if (neg_ff) begin
                        r = -r;
                     end
                     if (step_ff == STEP_LDIV) begin
                        left_ang_in = r;
                     end else begin
                        right_ang_in = r;
                     end
                  end
                  STEP_CORD2: begin
                     qz_in = sat16(cor_s >>> 15);
                     qw_in = sat16(cor_c >>> 15);
                  end
                  default: ;
               endcase
               if (step_ff == STEP_CORD2) begin
                  state_in = ST_EMIT;
               end else begin
                  step_in  = step_type'(step_ff + 5'd1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ticks_next = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
               finished   = ticks_next >= held_dur_ff;
               ticks_in   = ticks_next;
               active_in  = !finished;
               rsp_data_in.pos_x             = x_ff;
               rsp_data_in.pos_y             = y_ff;
               rsp_data_in.heading           = heading_ff;
               rsp_data_in.linear_speed      = v_ff;
               rsp_data_in.turn_rate         = omega_ff;
               rsp_data_in.quat_z            = qz_ff;
               rsp_data_in.quat_w            = qw_ff;
               rsp_data_in.left_wheel_angle  = left_ang_ff;
               rsp_data_in.right_wheel_angle = right_ang_ff;
               rsp_data_in.left_wheel_speed  = held_l_ff;
               rsp_data_in.right_wheel_speed = held_r_ff;
               rsp_data_in.command_done      = finished;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_OMEGA;
         ibw_ff       <= INV_WHEELBASE_RST;
         dt_ff        <= TICK_SECONDS_RST;
         gain_ff      <= WHEEL_GAIN_RST;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
         left_ang_ff  <= '0;
         right_ang_ff <= '0;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         held_dur_ff  <= '0;
         ticks_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ibw_ff       <= ibw_in;
         dt_ff        <= dt_in;
         gain_ff      <= gain_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
         left_ang_ff  <= left_ang_in;
         right_ang_ff <= right_ang_in;
         held_l_ff    <= held_l_in;
         held_r_ff    <= held_r_in;
         held_dur_ff  <= held_dur_in;
         ticks_ff     <= ticks_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      v_ff        <= v_in;
      omega_ff    <= omega_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      qz_ff       <= qz_in;
      qw_ff       <= qw_in;
      tmp_ff      <= tmp_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
   end

   ddo_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   ddo_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd_ff),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   ddo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_c),
      .sin_out (cor_s)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/ddo_checker.sv
// ---------------------------------------------------------------------------
// Odometry integrator checker
// Port-level assertions on the odometry block, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ddo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ddo_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ddo_pkg::rsp_type rsp_data
);
   import ddo_pkg::*;

   `DDO_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result beat after reset")
   `DDO_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped")
   `DDO_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "stalled result changed")
   `DDO_ASSERT(a_command_silent, clock, reset, req_valid && !req_stall && req_data.kind == KIND_COMMAND && !rsp_valid |=> !rsp_valid, "command beat produced a result")

endmodule

bind diff_drive_odometry_integrator ddo_checker u_ddo_checker (.*);

`default_nettype wire

### sim/diff_drive_odometry_integrator_tb.sv
// ---------------------------------------------------------------------------
// Odometry integrator testbench
// Drives command and tick beats with random gaps and result stalls, predicts
// every integration step from held speeds and register settings, and checks
// each result beat field by field against the oldest predicted pose.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_odometry_integrator_tb;
   import ddo_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int SETTLE_CYCLES = 700;

   class odometry_scoreboard;
      bit [15:0] inv_wheelbase, step_len, angle_gain;
      longint x_pos, y_pos, left_ang, right_ang;
      bit [31:0] head;
      logic signed [15:0] left_spd, right_spd;
      int unsigned hold_ticks, tick_count;
      bit running;
      rsp_type pose_queue[$];
      int errors;
      longint atan_q32[16] = '{
         'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
         'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
         'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D};

      function new();
         inv_wheelbase = INV_WHEELBASE_RST;
         step_len = TICK_SECONDS_RST;
         angle_gain = WHEEL_GAIN_RST;
         x_pos = 0; y_pos = 0; left_ang = 0; right_ang = 0; head = 0;
         left_spd = 0; right_spd = 0; hold_ticks = 0; tick_count = 0;
         running = 0; errors = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, bit [15:0] value);
         if (idx == CSR_INV_WHEELBASE) inv_wheelbase = value;
         else if (idx == CSR_TICK_SECONDS) step_len = value;
         else if (idx == CSR_WHEEL_GAIN) angle_gain = value;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint floor_div(longint a, longint b);
         longint q;
         q = a / b;
         if (a % b != 0 && a < 0) q--;
         return q;
      endfunction

      function void sin_cos(bit [31:0] a, output longint c, output longint s);
         bit flip;
         longint x, y, z, dx, dy;
         flip = 0;
         x = longint'(CORDIC_GAIN);
         y = 0;
         if (((a + 32'h40000000) & 32'h80000000) != 0) begin
            a = a + 32'h80000000;
            flip = 1;
         end
         z = longint'($signed(a));
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q32[i];
            end else begin
               x += dx; y -= dy; z += atan_q32[i];
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function void note_input(req_type b);
         longint v, om, c, s, dt, dh, t;
         rsp_type e;
         if (b.kind == KIND_COMMAND) begin
            left_spd = b.left_vel;
            right_spd = b.right_vel;
            hold_ticks = 32'(b.duration_ticks);
            tick_count = 0;
            running = 1;
            return;
         end
         if (!running) return;
         dt = longint'(step_len);
         v = (longint'(left_spd) + longint'(right_spd)) >>> 1;
         om = ((longint'(right_spd) - longint'(left_spd)) * longint'(inv_wheelbase)) >>> 8;
         om = clip(om, -8388608, 8388607);
         sin_cos(head << 1, c, s);
         x_pos = clip(x_pos + floor_div(((v * c) >>> 20) * dt, longint'(CM_TO_M_DIV)),
                      -64'sd2147483648, 64'sd2147483647);
         y_pos = clip(y_pos + floor_div(((v * s) >>> 20) * dt, longint'(CM_TO_M_DIV)),
                      -64'sd2147483648, 64'sd2147483647);
         dh = (om * dt * longint'(INV_4PI_Q24)) >>> 24;
         head = head + dh[31:0];
         left_ang = (left_ang + ((longint'(left_spd) * longint'(angle_gain) * dt) >>> 12))
                    % longint'(WRAP_2PI_Q28);
         right_ang = (right_ang + ((longint'(right_spd) * longint'(angle_gain) * dt) >>> 12))
                     % longint'(WRAP_2PI_Q28);
         if (tick_count < 65535) tick_count++;
         e.command_done = tick_count >= hold_ticks;
         if (e.command_done) running = 0;
         sin_cos(head, c, s);
         e.pos_x = x_pos[31:0];
         e.pos_y = y_pos[31:0];
         e.heading = head;
         e.linear_speed = v[15:0];
         e.turn_rate = om[23:0];
         t = clip(s >>> 15, -32768, 32767);
         e.quat_z = t[15:0];
         t = clip(c >>> 15, -32768, 32767);
         e.quat_w = t[15:0];
         e.left_wheel_angle = left_ang[31:0];
         e.right_wheel_angle = right_ang[31:0];
         e.left_wheel_speed = left_spd;
         e.right_wheel_speed = right_spd;
         pose_queue.push_back(e);
      endfunction

      task report(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_result(rsp_type r);
         rsp_type e;
         if (pose_queue.size() == 0) begin
            report("result beat with no expected pose");
            return;
         end
         e = pose_queue.pop_front();
         check_field("pos_x", r.pos_x, e.pos_x);
         check_field("pos_y", r.pos_y, e.pos_y);
         check_field("heading", r.heading, e.heading);
         check_field("linear_speed", r.linear_speed, e.linear_speed);
         check_field("turn_rate", r.turn_rate, e.turn_rate);
         check_field("quat_z", r.quat_z, e.quat_z);
         check_field("quat_w", r.quat_w, e.quat_w);
         check_field("left_wheel_angle", r.left_wheel_angle, e.left_wheel_angle);
         check_field("right_wheel_angle", r.right_wheel_angle, e.right_wheel_angle);
         check_field("left_wheel_speed", r.left_wheel_speed, e.left_wheel_speed);
         check_field("right_wheel_speed", r.right_wheel_speed, e.right_wheel_speed);
         check_field("command_done", r.command_done, e.command_done);
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int send_idle_pct, recv_idle_pct;
   odometry_scoreboard sb;

   diff_drive_odometry_integrator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   task send_beat(req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      sb.note_input(b);
      @(negedge clock);
   endtask

   task send_command(logic signed [15:0] l, logic signed [15:0] r, logic [15:0] d);
      req_type b;
      b.kind = KIND_COMMAND;
      b.left_vel = l;
      b.right_vel = r;
      b.duration_ticks = d;
      send_beat(b);
   endtask

   task send_tick();
      req_type b;
      b.kind = KIND_TICK;
      b.left_vel = 16'($urandom);
      b.right_vel = 16'($urandom);
      b.duration_ticks = 16'($urandom);
      send_beat(b);
   endtask

   task drain();
      req_valid <= 0;
      while (sb.pose_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      sb.write_register(idx, value);
      @(negedge clock);
      csr_write_enable <= 0;
      @(negedge clock);
   endtask

   task set_registers(logic [15:0] wb, logic [15:0] dt, logic [15:0] g);
      write_csr(CSR_INV_WHEELBASE, wb);
      write_csr(CSR_TICK_SECONDS, dt);
      write_csr(CSR_WHEEL_GAIN, g);
      write_csr(CSR_UNUSED, 16'($urandom));
   endtask

   function logic [15:0] pick_speed();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task random_traffic(int count);
      int sent, r, runs;
      logic [15:0] d;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         if (r < 10) begin
            send_tick();
            sent += 1;
         end else begin
            d = (r < 18) ? 16'($urandom) : 16'($urandom_range(5));
            send_command(pick_speed(), pick_speed(), d);
            runs = (d > 5) ? $urandom_range(1, 6) : d + 1;
            if ($urandom_range(9) == 0) runs = $urandom_range(runs);
            repeat (runs) send_tick();
            sent += 1 + runs;
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_stall = 0;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      send_idle_pct = 27;
      recv_idle_pct = 63;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      send_tick();
      send_command(16'sh7FFF, -16'sh8000, 16'd0);
      send_tick();
      send_command(-16'sh8000, 16'sh7FFF, 16'd2);
      repeat (3) send_tick();
      send_command(16'sd0, 16'sd0, 16'hFFFF);
      send_tick();
      send_command(16'sd256, 16'sd512, 16'd3);
      repeat (3) send_tick();
      send_command(-16'sd1, -16'sd1, 16'd1);
      send_tick();
      send_command(16'sh7FFF, 16'sh7FFF, 16'd1);
      send_tick();
      send_command(-16'sh8000, -16'sh8000, 16'd1);
      send_tick();
      random_traffic(230);
      drain();

      set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_idle_pct = 63;
      recv_idle_pct = 27;
      random_traffic(250);
      drain();

      set_registers(16'h0000, 16'h0000, 16'h0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(40);
      drain();

      set_registers(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom));
      random_traffic(250);
      drain();

      set_registers(16'h0000, 16'h0001, 16'h0000);
      random_traffic(200);
      drain();

      if (sb.errors == 0 && sb.pose_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
